FILE: rtl/core/crsf_pkg.sv
// ----------------------------------------------------------------------------
// crsf_pkg
// Shared types, codes and helpers of the CRSF frame receiver: parser
// phases, sequencer states, result kinds, the address list and the CRC step.
// ----------------------------------------------------------------------------
package crsf_pkg;

  typedef enum logic [2:0] {
    PH_ADDR    = 3'd0,
    PH_LEN     = 3'd1,
    PH_TYPE    = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC     = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    SQ_IDLE  = 2'd0,
    SQ_FETCH = 2'd1,
    SQ_MUL   = 2'd2,
    SQ_ADD   = 2'd3
  } seq_state_t;

  typedef enum logic [2:0] {
    K_CHAN    = 3'd0,
    K_ACCEPT  = 3'd1,
    K_BADADDR = 3'd2,
    K_BADLEN  = 3'd3,
    K_BADCRC  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    REG_DEST_ADDRESS  = 3'd0,
    REG_RC_FRAME_TYPE = 3'd1,
    REG_MAX_FRAME_LEN = 3'd2,
    REG_PWM_GAIN      = 3'd3,
    REG_PWM_OFFSET    = 3'd4
  } reg_index_t;

  localparam int CFG_W    = 27;
  localparam int BITPOS_W = 8;   // bit offset of a channel, up to 15 * 11
  localparam int IDX_W    = 8;   // byte index into the payload

  localparam logic [7:0]  MIN_FRAME_LEN  = 8'd2;
  localparam logic [7:0]  CRC_POLY       = 8'hD5;
  localparam logic [7:0]  CHAN_BITS      = 8'd11;
  localparam logic [11:0] PULSE_MAX      = 12'd4095;

  localparam logic [7:0]  RST_DEST_ADDRESS  = 8'd200;
  localparam logic [7:0]  RST_RC_FRAME_TYPE = 8'h16;
  localparam logic [5:0]  RST_MAX_FRAME_LEN = 6'd62;
  localparam logic [16:0] RST_PWM_GAIN      = 17'd40945;
  localparam logic [26:0] RST_PWM_OFFSET    = 27'd57707027;

  localparam int ADDR_COUNT = 13;
  localparam logic [7:0] ADDR_LIST [ADDR_COUNT] = '{
    8'h00, 8'h10, 8'h80, 8'h8A, 8'hC0, 8'hC2, 8'hC4,
    8'hC8, 8'hCA, 8'hCC, 8'hEA, 8'hEC, 8'hEE
  };

  function automatic logic addr_ok(input logic [7:0] b);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < ADDR_COUNT; i++) begin
      if (ADDR_LIST[i] == b) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/crsf_rc_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// crsf_rc_frame_receiver_top
// Byte-serial CRSF frame parser with CRC-8 check and RC channel scaling.
// ----------------------------------------------------------------------------
// Received bytes are refused while the channel sequencer runs or a result is
// stuck in the output register. A good RC channels frame for the configured
// destination then emits CHANNEL_COUNT channel items from a sequencer that
// walks the payload memory through its single read port: three byte reads,
// one multiply by the gain and one offset add per channel, plus any output
// stall; no byte is taken during this walk. Every other frame outcome gives
// one item at once.
module crsf_rc_frame_receiver_top #(
  parameter int PAYLOAD_DEPTH = 64,
  parameter int CHANNEL_COUNT = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rx_valid,
  output logic                      rx_stall,
  input  logic [7:0]                rx_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2:0]                kind,
  output logic [3:0]                channel_index,
  output logic [11:0]               pulse_us,
  output logic                      last,
  input  logic                      cfg_write,
  input  logic [2:0]                cfg_index,
  input  logic [crsf_pkg::CFG_W-1:0] cfg_data
);
  import crsf_pkg::*;

  localparam int AW = $clog2(PAYLOAD_DEPTH);

  // configuration
  logic [7:0]  dest_address;
  logic [7:0]  rc_frame_type;
  logic [5:0]  max_frame_len;
  logic [16:0] pwm_gain;
  logic [26:0] pwm_offset;

  // parser state
  phase_t     phase, phase_next;
  logic [7:0] frame_address, frame_address_next;
  logic [5:0] frame_length, frame_length_next;
  logic [7:0] frame_kind, frame_kind_next;
  logic [5:0] payload_count, payload_count_next;
  logic [7:0] running_crc, running_crc_next;

  // channel sequencer
  seq_state_t          seq, seq_next;
  logic [3:0]          ch, ch_next;
  logic [BITPOS_W-1:0] bitpos, bitpos_next;
  logic [1:0]          fetch, fetch_next;
  logic [5:0]          plen, plen_next;
  logic [23:0]         window, window_next;
  logic [27:0]         prod, prod_next;

  // payload memory
  logic [7:0]  mem [PAYLOAD_DEPTH];
  logic [7:0]  rd_q;
  logic        rd_ok_q;
  logic        mem_we;
  logic [IDX_W-1:0] rd_idx;
  logic        rd_ok;

  // output register
  logic        out_valid_next;
  logic [2:0]  kind_next;
  logic [3:0]  channel_index_next;
  logic [11:0] pulse_us_next;
  logic        last_next;

  logic        out_free;
  logic        rx_take;
  logic        ch_last;
  logic [7:0]  crc_b;
  logic [5:0]  count_inc;
  logic [7:0]  byte_val;
  logic [10:0] raw;
  logic [28:0] sum;
  logic [12:0] us;

  assign out_free = !out_valid || !out_stall;
  assign rx_stall = (seq != SQ_IDLE) || !out_free;
  assign rx_take  = rx_valid && !rx_stall;
  assign ch_last  = (ch == 4'(CHANNEL_COUNT - 1));

  assign crc_b     = crc_step((phase == PH_TYPE) ? 8'd0 : running_crc, rx_byte);
  assign count_inc = payload_count + 6'd1;
  assign mem_we    = rx_take && (phase == PH_PAYLOAD) && (int'(payload_count) < PAYLOAD_DEPTH);

  assign rd_idx   = {3'b000, bitpos[BITPOS_W-1:3]} + {6'b000000, fetch};
  assign rd_ok    = (rd_idx < {2'b00, plen}) && ({1'b0, rd_idx} < 9'(PAYLOAD_DEPTH));
  assign byte_val = rd_ok_q ? rd_q : 8'd0;
  assign raw      = 11'(window >> bitpos[2:0]);
  assign sum      = {1'b0, prod} + {2'b00, pwm_offset};
  assign us       = sum[28:16];

  always_ff @(posedge clk) begin
    if (mem_we) mem[AW'(payload_count)] <= rx_byte;
    rd_q    <= mem[rd_idx[AW-1:0]];
    rd_ok_q <= rd_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_address  <= RST_DEST_ADDRESS;
      rc_frame_type <= RST_RC_FRAME_TYPE;
      max_frame_len <= RST_MAX_FRAME_LEN;
      pwm_gain      <= RST_PWM_GAIN;
      pwm_offset    <= RST_PWM_OFFSET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEST_ADDRESS:  dest_address  <= cfg_data[7:0];
        REG_RC_FRAME_TYPE: rc_frame_type <= cfg_data[7:0];
        REG_MAX_FRAME_LEN: max_frame_len <= cfg_data[5:0];
        REG_PWM_GAIN:      pwm_gain      <= cfg_data[16:0];
        REG_PWM_OFFSET:    pwm_offset    <= cfg_data[26:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_ADDR;
      frame_address <= 8'd0;
      frame_length  <= 6'd0;
      frame_kind    <= 8'd0;
      payload_count <= 6'd0;
      running_crc   <= 8'd0;
      seq           <= SQ_IDLE;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      frame_address <= frame_address_next;
      frame_length  <= frame_length_next;
      frame_kind    <= frame_kind_next;
      payload_count <= payload_count_next;
      running_crc   <= running_crc_next;
      seq           <= seq_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ch            <= ch_next;
    bitpos        <= bitpos_next;
    fetch         <= fetch_next;
    plen          <= plen_next;
    window        <= window_next;
    prod          <= prod_next;
    kind          <= kind_next;
    channel_index <= channel_index_next;
    pulse_us      <= pulse_us_next;
    last          <= last_next;
  end

  always_comb begin
    phase_next         = phase;
    frame_address_next = frame_address;
    frame_length_next  = frame_length;
    frame_kind_next    = frame_kind;
    payload_count_next = payload_count;
    running_crc_next   = running_crc;
    seq_next           = seq;
    ch_next            = ch;
    bitpos_next        = bitpos;
    fetch_next         = fetch;
    plen_next          = plen;
    window_next        = window;
    prod_next          = prod;
    out_valid_next     = out_valid && out_stall;
    kind_next          = kind;
    channel_index_next = channel_index;
    pulse_us_next      = pulse_us;
    last_next          = last;

    if (rx_take) begin
      unique case (phase)
        PH_ADDR: begin
          if (addr_ok(rx_byte)) begin
            frame_address_next = rx_byte;
            phase_next         = PH_LEN;
          end else begin
            out_valid_next     = 1'b1;
            kind_next          = K_BADADDR;
          end
        end
        PH_LEN: begin
          if (rx_byte < MIN_FRAME_LEN || rx_byte > {2'b00, max_frame_len}) begin
            out_valid_next = 1'b1;
            kind_next      = K_BADLEN;
            phase_next     = PH_ADDR;
          end else begin
            frame_length_next  = rx_byte[5:0];
            payload_count_next = 6'd0;
            phase_next         = PH_TYPE;
          end
        end
        PH_TYPE: begin
          frame_kind_next  = rx_byte;
          running_crc_next = crc_b;
          phase_next       = (frame_length > 6'd2) ? PH_PAYLOAD : PH_CRC;
        end
        PH_PAYLOAD: begin
          running_crc_next   = crc_b;
          payload_count_next = count_inc;
          if (count_inc >= frame_length - 6'd2) phase_next = PH_CRC;
        end
        PH_CRC: begin
          phase_next = PH_ADDR;
          if (rx_byte != running_crc) begin
            out_valid_next = 1'b1;
            kind_next      = K_BADCRC;
          end else if (frame_address == dest_address && frame_kind == rc_frame_type) begin
            seq_next    = SQ_FETCH;
            ch_next     = 4'd0;
            bitpos_next = '0;
            fetch_next  = 2'd0;
            plen_next   = frame_length - 6'd2;
          end else begin
            out_valid_next = 1'b1;
            kind_next      = K_ACCEPT;
          end
        end
        default: phase_next = PH_ADDR;
      endcase

      // drop the frame context whenever the parser returns to the address phase
      if (phase_next == PH_ADDR) begin
        frame_address_next = 8'd0;
        frame_length_next  = 6'd0;
        frame_kind_next    = 8'd0;
        payload_count_next = 6'd0;
        running_crc_next   = 8'd0;
      end
      if (out_valid_next) begin
        channel_index_next = 4'd0;
        pulse_us_next      = 12'd0;
        last_next          = 1'b1;
      end
    end

    unique case (seq)
      SQ_IDLE: ;
      SQ_FETCH: begin
        // read data is registered and arrives the cycle after its address
        if (fetch != 2'd0) window_next = {byte_val, window[23:8]};
        fetch_next = fetch + 2'd1;
        if (fetch == 2'd3) seq_next = SQ_MUL;
      end
      SQ_MUL: begin
        prod_next = {17'd0, raw} * {11'd0, pwm_gain};
        seq_next  = SQ_ADD;
      end
      SQ_ADD: begin
        // hold until the output register can take the item
        if (out_free) begin
          out_valid_next     = 1'b1;
          kind_next          = K_CHAN;
          channel_index_next = ch;
          pulse_us_next      = (us > {1'b0, PULSE_MAX}) ? PULSE_MAX : us[11:0];
          last_next          = ch_last;
          if (ch_last) begin
            seq_next = SQ_IDLE;
          end else begin
            ch_next     = ch + 4'd1;
            bitpos_next = bitpos + CHAN_BITS;
            fetch_next  = 2'd0;
            seq_next    = SQ_FETCH;
          end
        end
      end
      default: seq_next = SQ_IDLE;
    endcase
  end

  a_chan_load: assert property (@(posedge clk) disable iff (rst)
    (seq == SQ_ADD && out_free) |=> (out_valid && kind == K_CHAN))
    else $error("channel item not loaded into output register");

  a_plain_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != K_CHAN) |-> (channel_index == 4'd0 && pulse_us == 12'd0 && last))
    else $error("non-channel item carries channel fields");

  a_rc_start: assert property (@(posedge clk) disable iff (rst)
    (rx_take && phase == PH_CRC && rx_byte == running_crc &&
     frame_address == dest_address && frame_kind == rc_frame_type)
    |=> (seq == SQ_FETCH && ch == 4'd0))
    else $error("good RC frame did not start channel walk");

  a_fetch_done: assert property (@(posedge clk) disable iff (rst)
    (seq == SQ_FETCH && fetch == 2'd3) |=> (seq == SQ_MUL))
    else $error("byte fetch did not hand over to multiply");

endmodule
